// ===== hdl/ldm_pkg.sv =====
// Shared constants and helpers for the lens distortion map pipeline.
// Used by ldm_div, ldm_mul and lens_distortion_map; depends on nothing.
package ldm_pkg;

  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RADIAL_K1  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RADIAL_K2  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RADIAL_K3  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TANGENTIAL = 4'd7;

  localparam logic [63:0] LIM  = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] QONE = 64'h0000_0000_1000_0000;

  localparam int QBITS    = 61;
  localparam int DIV_LAT  = QBITS + 3;
  localparam int MUL_LAT  = 5;
  localparam int POST_LAT = 36;

  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (s > $signed(LIM)) begin
      return $signed(LIM);
    end else if (s < -$signed(LIM)) begin
      return -$signed(LIM);
    end
    return s;
  endfunction

  function automatic logic signed [63:0] sext32(input logic [31:0] v);
    return $signed({{32{v[31]}}, v});
  endfunction

endpackage

// ===== hdl/ldm_delay.sv =====
// Fixed-depth register delay line with a common clock enable.
// Stand-alone; used by lens_distortion_map to align pipeline branches.
module ldm_delay #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             ce,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] stg [DEPTH];

  always_ff @(posedge clk) begin
    if (ce) begin
      stg[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        stg[i] <= stg[i-1];
      end
    end
  end

  assign q = stg[DEPTH-1];

endmodule

// ===== hdl/ldm_mul.sv =====
// Pipelined signed multiply with rounded right shift and saturation.
// Splits the magnitudes into 32-bit and 30-bit halves for four partial products; uses ldm_pkg.
module ldm_mul #(
  parameter int SHIFT = 28
) (
  input  logic               clk,
  input  logic               ce,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic signed [63:0] p
);

  localparam int PW = 125;
  localparam int QW = PW - SHIFT;
  localparam logic [PW-1:0] HALF = PW'(1) << (SHIFT - 1);

  logic          sgn1, sgn2, sgn3, sgn4;
  logic [61:0]   ma, mb;
  logic [63:0]   ll2, ll3;
  logic [61:0]   lh2, hl2;
  logic [59:0]   hh2, hh3;
  logic [62:0]   mid3;
  logic [PW-1:0] prod4;
  logic [QW-1:0] qv;
  logic [61:0]   mag;

  always_ff @(posedge clk) begin
    if (ce) begin
      sgn1 <= a[63] ^ b[63];
      ma   <= a[63] ? 62'(-a) : a[61:0];
      mb   <= b[63] ? 62'(-b) : b[61:0];
      sgn2 <= sgn1;
      ll2  <= ma[31:0] * mb[31:0];
      lh2  <= ma[31:0] * mb[61:32];
      hl2  <= ma[61:32] * mb[31:0];
      hh2  <= ma[61:32] * mb[61:32];
      sgn3 <= sgn2;
      mid3 <= {1'b0, lh2} + {1'b0, hl2};
      ll3  <= ll2;
      hh3  <= hh2;
      sgn4 <= sgn3;
      prod4 <= {1'b0, hh3, 64'b0} + {30'b0, mid3, 32'b0} + {61'b0, ll3} + HALF;
      p <= sgn4 ? -$signed({2'b0, mag}) : $signed({2'b0, mag});
    end
  end

  always_comb begin
    qv  = prod4[PW-1:SHIFT];
    mag = (qv > QW'(ldm_pkg::LIM)) ? ldm_pkg::LIM[61:0] : qv[61:0];
  end

endmodule

// ===== hdl/ldm_div.sv =====
// Pipelined coordinate normalizer: (pix - center) / focal in Q.28, rounded.
// Restoring division with one quotient bit per stage; uses ldm_pkg.
module ldm_div (
  input  logic               clk,
  input  logic               ce,
  input  logic [11:0]        pix,
  input  logic [31:0]        center,
  input  logic [31:0]        focal,
  output logic signed [63:0] quo
);

  localparam int QB = ldm_pkg::QBITS;

  logic [31:0]        fdiv;
  logic signed [33:0] num_q;
  logic [31:0]        mag;
  logic [31:0]        rem_q [QB+1];
  logic [QB-1:0]      dq_q  [QB+1];
  logic               neg_q [QB+1];

  assign fdiv = (focal == 32'd0) ? 32'd1 : focal;
  assign mag  = num_q[33] ? 32'(-num_q) : num_q[31:0];

  always_ff @(posedge clk) begin
    if (ce) begin
      num_q    <= $signed({6'b0, pix, 16'b0}) - $signed({2'b0, center});
      rem_q[0] <= '0;
      dq_q[0]  <= {1'b0, mag, 28'b0} + {30'b0, fdiv[31:1]};
      neg_q[0] <= num_q[33];
      quo <= neg_q[QB] ? -$signed({3'b0, dq_q[QB]}) : $signed({3'b0, dq_q[QB]});
    end
  end

  for (genvar s = 1; s <= QB; s++) begin : g_bit
    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;

    always_comb begin
      trial = {rem_q[s-1], dq_q[s-1][QB-1]};
      diff  = trial - {1'b0, fdiv};
      ge    = trial >= {1'b0, fdiv};
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_q[s] <= ge ? diff[31:0] : trial[31:0];
        dq_q[s]  <= {dq_q[s-1][QB-2:0], ge};
        neg_q[s] <= neg_q[s-1];
      end
    end
  end

endmodule

// ===== hdl/lens_distortion_map.sv =====
// Top level of the lens distortion map: registers, pipeline and output skid.
// Uses ldm_pkg, ldm_div, ldm_mul and ldm_delay.
//
// Each request carries an output pixel position and returns the distorted
// source position under the five-term radial and tangential lens model, in
// signed 1/256-pixel units with a clip flag in tuser. One request is taken
// every clock cycle while the skid register is empty. An accepted request
// passes the input register, the normalizing divider, which produces one
// quotient bit per stage, and the multiplier chain of the lens polynomial
// and the pixel scaling, whose multipliers take five stages each.
// A stalled output is held in a skid register, after which the whole
// pipeline holds. Register writes are taken at any time but belong between
// frames, when no request is in flight.
module lens_distortion_map #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [23:0]                    s_tdata,   // column[11:0], row[23:12]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [47:0]                    m_tdata,   // source_x[23:0], source_y[47:24]
  output logic                           m_tuser,   // clipped
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ldm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [63:0]                    cfg_data
);

  localparam int LAT = 1 + ldm_pkg::DIV_LAT + ldm_pkg::POST_LAT;
  localparam logic [16:0] MAXCOL = 17'(MAX_WIDTH - 1);
  localparam logic [16:0] MAXROW = 17'(MAX_HEIGHT - 1);

  logic [31:0] focal_x, focal_y, center_x, center_y;
  logic [31:0] radial_k1, radial_k2, radial_k3;
  logic [63:0] tangential_pair;

  logic signed [63:0] k1, k2, k3, p1, p2, fxs, fys;

  logic           ce;
  logic [LAT-1:0] vld;
  logic [11:0]    col_q, row_q;
  logic           skid_valid;
  logic [48:0]    skid_data;
  logic [48:0]    fin_data;
  logic           fin_v;

  logic signed [63:0] x_t0, y_t0, x_t23, y_t23;
  logic signed [63:0] xx_t5, yy_t5, xy_t5;
  logic signed [63:0] r2_t6, xx2_t6, yy2_t6, ax_t7, ay_t7;
  logic signed [63:0] r4_t11, k1r2_t11, r2_t11, ca_t12, ca_t22;
  logic signed [63:0] r6_t16, k2r4_t16, k2r4_t21, k3r6_t21, cb_t22, c_t23;
  logic signed [63:0] p1xy_t10, p2xy_t10, t1_t11, t2_t11, t1_t12, t2_t12;
  logic signed [63:0] p2ax_t12, p1ay_t12, tx_t13, ty_t13, tx_t28, ty_t28;
  logic signed [63:0] xc_t28, yc_t28, dx_t29, dy_t29, fx_t34, fy_t34;
  logic signed [63:0] wx_t35, wy_t35;
  logic signed [47:0] rx, ry;
  logic [23:0]        sx_t36, sy_t36;
  logic               clip_t36;

  assign cfg_ready = 1'b1;
  assign ce        = ~skid_valid;
  assign s_tready  = ce;

  assign k1  = ldm_pkg::sext32(radial_k1);
  assign k2  = ldm_pkg::sext32(radial_k2);
  assign k3  = ldm_pkg::sext32(radial_k3);
  assign p1  = ldm_pkg::sext32(tangential_pair[31:0]);
  assign p2  = ldm_pkg::sext32(tangential_pair[63:32]);
  assign fxs = $signed({32'b0, focal_x});
  assign fys = $signed({32'b0, focal_y});

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x         <= 32'h0001_0000;
      focal_y         <= 32'h0001_0000;
      center_x        <= '0;
      center_y        <= '0;
      radial_k1       <= '0;
      radial_k2       <= '0;
      radial_k3       <= '0;
      tangential_pair <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ldm_pkg::REG_FOCAL_X:    focal_x         <= cfg_data[31:0];
        ldm_pkg::REG_FOCAL_Y:    focal_y         <= cfg_data[31:0];
        ldm_pkg::REG_CENTER_X:   center_x        <= cfg_data[31:0];
        ldm_pkg::REG_CENTER_Y:   center_y        <= cfg_data[31:0];
        ldm_pkg::REG_RADIAL_K1:  radial_k1       <= cfg_data[31:0];
        ldm_pkg::REG_RADIAL_K2:  radial_k2       <= cfg_data[31:0];
        ldm_pkg::REG_RADIAL_K3:  radial_k3       <= cfg_data[31:0];
        ldm_pkg::REG_TANGENTIAL: tangential_pair <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      col_q <= ({5'b0, s_tdata[11:0]} > MAXCOL) ? MAXCOL[11:0] : s_tdata[11:0];
      row_q <= ({5'b0, s_tdata[23:12]} > MAXROW) ? MAXROW[11:0] : s_tdata[23:12];
    end
  end

  ldm_div u_div_x (.clk, .ce, .pix(col_q), .center(center_x), .focal(focal_x), .quo(x_t0));
  ldm_div u_div_y (.clk, .ce, .pix(row_q), .center(center_y), .focal(focal_y), .quo(y_t0));

  ldm_mul u_xx (.clk, .ce, .a(x_t0), .b(x_t0), .p(xx_t5));
  ldm_mul u_yy (.clk, .ce, .a(y_t0), .b(y_t0), .p(yy_t5));
  ldm_mul u_xy (.clk, .ce, .a(x_t0), .b(y_t0), .p(xy_t5));

  ldm_mul u_r4   (.clk, .ce, .a(r2_t6), .b(r2_t6), .p(r4_t11));
  ldm_mul u_k1r2 (.clk, .ce, .a(k1), .b(r2_t6), .p(k1r2_t11));
  ldm_mul u_r6   (.clk, .ce, .a(r4_t11), .b(r2_t11), .p(r6_t16));
  ldm_mul u_k2r4 (.clk, .ce, .a(k2), .b(r4_t11), .p(k2r4_t16));
  ldm_mul u_k3r6 (.clk, .ce, .a(k3), .b(r6_t16), .p(k3r6_t21));

  ldm_mul u_p1xy (.clk, .ce, .a(p1), .b(xy_t5), .p(p1xy_t10));
  ldm_mul u_p2xy (.clk, .ce, .a(p2), .b(xy_t5), .p(p2xy_t10));
  ldm_mul u_p2ax (.clk, .ce, .a(p2), .b(ax_t7), .p(p2ax_t12));
  ldm_mul u_p1ay (.clk, .ce, .a(p1), .b(ay_t7), .p(p1ay_t12));

  ldm_mul u_xc (.clk, .ce, .a(x_t23), .b(c_t23), .p(xc_t28));
  ldm_mul u_yc (.clk, .ce, .a(y_t23), .b(c_t23), .p(yc_t28));

  ldm_mul #(.SHIFT(20)) u_fx (.clk, .ce, .a(fxs), .b(dx_t29), .p(fx_t34));
  ldm_mul #(.SHIFT(20)) u_fy (.clk, .ce, .a(fys), .b(dy_t29), .p(fy_t34));

  ldm_delay #(.WIDTH(64), .DEPTH(23)) u_dly_x  (.clk, .ce, .d(x_t0), .q(x_t23));
  ldm_delay #(.WIDTH(64), .DEPTH(23)) u_dly_y  (.clk, .ce, .d(y_t0), .q(y_t23));
  ldm_delay #(.WIDTH(64), .DEPTH(5))  u_dly_r2 (.clk, .ce, .d(r2_t6), .q(r2_t11));
  ldm_delay #(.WIDTH(64), .DEPTH(10)) u_dly_ca (.clk, .ce, .d(ca_t12), .q(ca_t22));
  ldm_delay #(.WIDTH(64), .DEPTH(5))  u_dly_k2 (.clk, .ce, .d(k2r4_t16), .q(k2r4_t21));
  ldm_delay #(.WIDTH(64), .DEPTH(15)) u_dly_tx (.clk, .ce, .d(tx_t13), .q(tx_t28));
  ldm_delay #(.WIDTH(64), .DEPTH(15)) u_dly_ty (.clk, .ce, .d(ty_t13), .q(ty_t28));

  always_ff @(posedge clk) begin
    if (ce) begin
      r2_t6  <= ldm_pkg::sadd(xx_t5, yy_t5);
      xx2_t6 <= ldm_pkg::sadd(xx_t5, xx_t5);
      yy2_t6 <= ldm_pkg::sadd(yy_t5, yy_t5);
      ax_t7  <= ldm_pkg::sadd(r2_t6, xx2_t6);
      ay_t7  <= ldm_pkg::sadd(r2_t6, yy2_t6);
      t1_t11 <= ldm_pkg::sadd(p1xy_t10, p1xy_t10);
      t2_t11 <= ldm_pkg::sadd(p2xy_t10, p2xy_t10);
      t1_t12 <= t1_t11;
      t2_t12 <= t2_t11;
      ca_t12 <= ldm_pkg::sadd($signed(ldm_pkg::QONE), k1r2_t11);
      tx_t13 <= ldm_pkg::sadd(t1_t12, p2ax_t12);
      ty_t13 <= ldm_pkg::sadd(p1ay_t12, t2_t12);
      cb_t22 <= ldm_pkg::sadd(k2r4_t21, k3r6_t21);
      c_t23  <= ldm_pkg::sadd(ca_t22, cb_t22);
      dx_t29 <= ldm_pkg::sadd(xc_t28, tx_t28);
      dy_t29 <= ldm_pkg::sadd(yc_t28, ty_t28);
      wx_t35 <= fx_t34 + $signed({24'b0, center_x, 8'b0}) + 64'sd32768;
      wy_t35 <= fy_t34 + $signed({24'b0, center_y, 8'b0}) + 64'sd32768;
      sx_t36 <= (rx > 48'sd8388607) ? 24'h7F_FFFF :
                (rx < -48'sd8388608) ? 24'h80_0000 : rx[23:0];
      sy_t36 <= (ry > 48'sd8388607) ? 24'h7F_FFFF :
                (ry < -48'sd8388608) ? 24'h80_0000 : ry[23:0];
      clip_t36 <= (rx > 48'sd8388607) || (rx < -48'sd8388608) ||
                  (ry > 48'sd8388607) || (ry < -48'sd8388608);
    end
  end

  assign rx = wx_t35[63:16];
  assign ry = wy_t35[63:16];

  assign fin_v    = vld[LAT-1] & ce;
  assign fin_data = {clip_t36, sy_t36, sx_t36};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !m_tvalid) begin
      m_tvalid   <= skid_valid || fin_v;
      skid_valid <= 1'b0;
    end else if (fin_v) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !m_tvalid) begin
      {m_tuser, m_tdata} <= skid_valid ? skid_data : fin_data;
    end else if (fin_v) begin
      skid_data <= fin_data;
    end
  end

`ifndef ASSERT_OFF
  a_skid_has_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid register holds a result while the output is empty");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !ce |=> $stable(vld))
    else $error("pipeline valid bits moved during a stall");

  a_clip_extreme: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[23:0] == 24'h7F_FFFF ||
                               m_tdata[23:0] == 24'h80_0000 ||
                               m_tdata[47:24] == 24'h7F_FFFF ||
                               m_tdata[47:24] == 24'h80_0000))
    else $error("clip flag set without a saturated coordinate");
`endif

endmodule
